>>> rtl/sfbp_pkg.sv
// shared types, widths and constants of the sorted file bin packer
package sfbp_pkg;

	localparam int MAX_FILES = 64;
	localparam int IDX_W     = $clog2(MAX_FILES);
	localparam int CNT_W     = $clog2(MAX_FILES + 1);

	localparam int SIZE_W    = 40;
	localparam int COST_W    = SIZE_W + 1;
	localparam int TOT_W     = 48;
	localparam int SLOT_W    = 6;
	localparam int GRP_W     = 6;
	localparam int MINF_W    = 7;
	localparam int CFG_IDX_W = 2;

	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_COST   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_FILES   = 2'd2;

	localparam logic [SIZE_W-1:0] TARGET_SIZE_RST = 40'd134217728;
	localparam logic [SIZE_W-1:0] OPEN_COST_RST   = 40'd4194304;
	localparam logic [MINF_W-1:0] MIN_FILES_RST   = 7'd5;

	typedef struct packed {
		logic [SIZE_W-1:0] target_size;
		logic [SIZE_W-1:0] open_cost;
		logic [MINF_W-1:0] min_files;
	} cfg_t;

	// classified item passed from front to back
	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [SLOT_W-1:0] slot;
		logic              store;
		logic              last;
		logic              overflow;
	} cmd_t;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [SLOT_W-1:0] slot;
	} entry_t;

	typedef struct packed {
		logic [SLOT_W-1:0] file_slot;
		logic [GRP_W-1:0]  group_number;
		logic              group_end;
		logic              run_end;
		logic              no_groups;
		logic              too_many;
	} res_t;

endpackage

>>> rtl/sfbp_front.sv
// front part: accepts items, numbers stored files and flags dropped ones
module sfbp_front import sfbp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [SIZE_W-1:0] file_bytes,
	input  logic              last_file,
	input  logic              q_full,
	output logic              q_push,
	output cmd_t              q_cmd
);

	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic             accept;
	logic             store;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign store  = (cnt_q < CNT_W'(MAX_FILES));

	// dropped files that do not end the set never reach the back part
	assign q_push = accept && (store || last_file);

	always_comb begin
		q_cmd.size     = file_bytes;
		q_cmd.slot     = SLOT_W'(cnt_q);
		q_cmd.store    = store;
		q_cmd.last     = last_file;
		q_cmd.overflow = ovf_q || !store;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (last_file) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (store) begin
				cnt_q <= CNT_W'(cnt_q + CNT_W'(1));
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

endmodule

>>> rtl/sfbp_cmd_queue.sv
// short queue of classified items between front and back
module sfbp_cmd_queue import sfbp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t din,
	output logic full,
	input  logic rd,
	output cmd_t dout,
	output logic empty
);

	cmd_t            mem_q [QDEPTH];
	logic [QPTR_W:0] wptr_q;
	logic [QPTR_W:0] rptr_q;

	assign empty = (wptr_q == rptr_q);
	assign full  = (wptr_q[QPTR_W] != rptr_q[QPTR_W]) &&
	               (wptr_q[QPTR_W-1:0] == rptr_q[QPTR_W-1:0]);
	assign dout  = mem_q[rptr_q[QPTR_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (wr && !full) begin
				wptr_q <= wptr_q + (QPTR_W+1)'(1);
			end
			if (rd && !empty) begin
				rptr_q <= rptr_q + (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem_q[wptr_q[QPTR_W-1:0]] <= din;
		end
	end

endmodule

>>> rtl/sfbp_back.sv
// back part: insertion sort into the file memory, then two packing passes
module sfbp_back import sfbp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic q_empty,
	output logic q_pop,
	input  cmd_t q_cmd,
	input  logic o_full,
	output logic o_push,
	output res_t o_res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_PLACE,
		ST_SCAN1,
		ST_SCAN2,
		ST_MARK
	} state_t;

	localparam logic [CNT_W-1:0] ONE = CNT_W'(1);
	localparam logic [CNT_W-1:0] TWO = CNT_W'(2);

	state_t           state_q;
	cmd_t             cur_q;
	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	entry_t           rd_q;
	entry_t           mem_q [MAX_FILES];

	logic [CNT_W-1:0]  rd_idx_q;
	logic              v_s1_q;
	logic              last_s1_q;
	logic [CNT_W-1:0]  idx_s1_q;
	logic              v_s2_q;
	logic              last_s2_q;
	logic [CNT_W-1:0]  idx_s2_q;
	logic [SLOT_W-1:0] slot_s2;
	logic [COST_W-1:0] cost_s2;
	logic [TOT_W-1:0]  total_q;
	logic [CNT_W-1:0]  start_q;
	logic [GRP_W-1:0]  grp_q;
	logic [CNT_W-1:0]  end_q;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_wa;
	entry_t            mem_wd;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_ra;

	logic              scanning;
	logic              adv;
	logic [CNT_W-1:0]  n_scan;
	logic              issue;
	logic [TOT_W-1:0]  tot_sum;
	logic [TOT_W-1:0]  limit;
	logic              close;
	logic [CNT_W-1:0]  start_nxt;
	logic [CNT_W-1:0]  left;
	logic              emit_left;
	logic [CNT_W-1:0]  end_nxt;
	logic              pass1_done;
	logic              pass2_done;
	logic              shift_more;
	entry_t            cur_ent;

	assign q_pop      = (state_q == ST_IDLE) && !q_empty;
	assign cur_ent    = '{size: cur_q.size, slot: cur_q.slot};
	assign shift_more = (rd_q.size > cur_q.size);

	assign scanning   = (state_q == ST_SCAN1) || (state_q == ST_SCAN2);
	assign adv        = !((state_q == ST_SCAN2) && o_full);
	assign n_scan     = (state_q == ST_SCAN1) ? cnt_q : end_q;
	assign issue      = scanning && adv && (rd_idx_q < n_scan);

	// running bin total and the closing rule
	assign tot_sum    = total_q + TOT_W'(cost_s2);
	assign limit      = TOT_W'({cfg.target_size, 1'b0});
	assign close      = (idx_s2_q > start_q) && (tot_sum >= limit);
	assign start_nxt  = (v_s2_q && close) ? CNT_W'(idx_s2_q + ONE) : start_q;

	// leftover bin goes out only if non-empty and large enough
	assign left       = CNT_W'(cnt_q - start_nxt);
	assign emit_left  = (left != '0) && (MINF_W'(left) >= cfg.min_files);
	assign end_nxt    = emit_left ? cnt_q : start_nxt;

	assign pass1_done = (state_q == ST_SCAN1) && v_s2_q && last_s2_q;
	assign pass2_done = (state_q == ST_SCAN2) && v_s2_q && last_s2_q && adv;

	assign o_push = ((state_q == ST_SCAN2) && v_s2_q && !o_full) ||
	                ((state_q == ST_MARK) && !o_full);

	always_comb begin
		if (state_q == ST_MARK) begin
			o_res.file_slot    = '0;
			o_res.group_number = '0;
			o_res.group_end    = 1'b0;
			o_res.run_end      = 1'b1;
			o_res.no_groups    = 1'b1;
		end else begin
			o_res.file_slot    = slot_s2;
			o_res.group_number = grp_q;
			o_res.group_end    = close || last_s2_q;
			o_res.run_end      = last_s2_q;
			o_res.no_groups    = 1'b0;
		end
		o_res.too_many = ovf_q;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = cur_ent;
		mem_re = 1'b0;
		mem_ra = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_pop && q_cmd.store) begin
					if (cnt_q == '0) begin
						mem_we = 1'b1;
						mem_wd = '{size: q_cmd.size, slot: q_cmd.slot};
					end else begin
						mem_re = 1'b1;
						mem_ra = IDX_W'(cnt_q - ONE);
					end
				end
			end
			ST_SHIFT: begin
				mem_we = 1'b1;
				mem_wa = IDX_W'(pos_q);
				if (shift_more) begin
					mem_wd = rd_q;
					if (pos_q != ONE) begin
						mem_re = 1'b1;
						mem_ra = IDX_W'(pos_q - TWO);
					end
				end
			end
			ST_PLACE: begin
				mem_we = 1'b1;
				mem_wa = IDX_W'(pos_q);
			end
			ST_SCAN1, ST_SCAN2: begin
				mem_re = issue;
				mem_ra = IDX_W'(rd_idx_q);
			end
			ST_MARK: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem_q[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_cmd;
		end
		if (adv) begin
			cost_s2 <= COST_W'(rd_q.size) + COST_W'(cfg.open_cost);
			slot_s2 <= rd_q.slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			rd_idx_q  <= '0;
			v_s1_q    <= 1'b0;
			last_s1_q <= 1'b0;
			idx_s1_q  <= '0;
			v_s2_q    <= 1'b0;
			last_s2_q <= 1'b0;
			idx_s2_q  <= '0;
			total_q   <= '0;
			start_q   <= '0;
			grp_q     <= '0;
			end_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					rd_idx_q <= '0;
					v_s1_q   <= 1'b0;
					v_s2_q   <= 1'b0;
					total_q  <= '0;
					start_q  <= '0;
					grp_q    <= '0;
					if (q_pop) begin
						ovf_q <= q_cmd.overflow;
						if (q_cmd.store) begin
							if (cnt_q == '0) begin
								cnt_q <= ONE;
								if (q_cmd.last) begin
									state_q <= ST_SCAN1;
								end
							end else begin
								pos_q   <= cnt_q;
								state_q <= ST_SHIFT;
							end
						end else begin
							state_q <= ST_SCAN1;
						end
					end
				end
				ST_SHIFT: begin
					if (shift_more) begin
						pos_q <= CNT_W'(pos_q - ONE);
						if (pos_q == ONE) begin
							state_q <= ST_PLACE;
						end
					end else begin
						cnt_q   <= CNT_W'(cnt_q + ONE);
						state_q <= cur_q.last ? ST_SCAN1 : ST_IDLE;
					end
				end
				ST_PLACE: begin
					cnt_q   <= CNT_W'(cnt_q + ONE);
					state_q <= cur_q.last ? ST_SCAN1 : ST_IDLE;
				end
				ST_SCAN1, ST_SCAN2: begin
					if (adv) begin
						// first pass over: rerun the same grouping to emit
						if (pass1_done) begin
							end_q    <= end_nxt;
							rd_idx_q <= '0;
							v_s1_q   <= 1'b0;
							v_s2_q   <= 1'b0;
							total_q  <= '0;
							start_q  <= '0;
							grp_q    <= '0;
							state_q  <= (end_nxt != '0) ? ST_SCAN2 : ST_MARK;
						end else begin
							if (issue) begin
								rd_idx_q  <= CNT_W'(rd_idx_q + ONE);
								v_s1_q    <= 1'b1;
								idx_s1_q  <= rd_idx_q;
								last_s1_q <= (CNT_W'(rd_idx_q + ONE) == n_scan);
							end else begin
								v_s1_q <= 1'b0;
							end
							v_s2_q    <= v_s1_q;
							idx_s2_q  <= idx_s1_q;
							last_s2_q <= last_s1_q;
							if (v_s2_q) begin
								total_q <= close ? '0 : tot_sum;
								start_q <= start_nxt;
								if ((state_q == ST_SCAN2) && (close || last_s2_q)) begin
									grp_q <= GRP_W'(grp_q + GRP_W'(1));
								end
							end
							if (pass2_done) begin
								cnt_q   <= '0;
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_MARK: begin
					if (!o_full) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/sfbp_res_queue.sv
// result queue in front of the output ports
module sfbp_res_queue import sfbp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  res_t din,
	output logic full,
	input  logic rd,
	output res_t dout,
	output logic empty
);

	res_t            mem_q [QDEPTH];
	logic [QPTR_W:0] wptr_q;
	logic [QPTR_W:0] rptr_q;

	assign empty = (wptr_q == rptr_q);
	assign full  = (wptr_q[QPTR_W] != rptr_q[QPTR_W]) &&
	               (wptr_q[QPTR_W-1:0] == rptr_q[QPTR_W-1:0]);
	assign dout  = mem_q[rptr_q[QPTR_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (wr && !full) begin
				wptr_q <= wptr_q + (QPTR_W+1)'(1);
			end
			if (rd && !empty) begin
				rptr_q <= rptr_q + (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem_q[wptr_q[QPTR_W-1:0]] <= din;
		end
	end

endmodule

>>> rtl/sorted_file_bin_packer.sv
// top level of the sorted file bin packer: config registers and the two parts
//
// input side is a queue: an item (file_bytes, last_file) goes in at a rising edge with
// push high and full low. files are kept sorted by size, ties in arrival order;
// the item with last_file high closes the set and starts packing.
// result side is a queue too: while empty is low the oldest result sits on file_slot,
// group_number, group_end, run_end, no_groups and too_many; pop takes it.
// loading: a four-deep queue takes items at one per cycle while it is not full; the sorter
// then places each file by an insertion that walks down the file memory one entry a cycle,
// past the k held files larger than it (the first file of a set needs no walk).
// packing: a first pass over the n sorted files, then a second pass over the m grouped
// files that pushes one result per cycle while the result queue is not full; a set with
// no group yields one marker item instead.
// a stalled receiver fills the result queue and then freezes the packing pass;
// the front keeps taking items until its queue is full.
// files beyond 64 in a set are dropped and too_many is set on that set's results.
// reset clears all control state; the file memory is never cleared, only written
// entries are read. config writes (cfg_we, cfg_idx, cfg_data) are registered.
module sorted_file_bin_packer import sfbp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [SIZE_W-1:0]    cfg_data,
	// input item channel
	input  logic                 push,
	output logic                 full,
	input  logic [SIZE_W-1:0]    file_bytes,
	input  logic                 last_file,
	// result item channel
	output logic                 empty,
	input  logic                 pop,
	output logic [SLOT_W-1:0]    file_slot,
	output logic [GRP_W-1:0]     group_number,
	output logic                 group_end,
	output logic                 run_end,
	output logic                 no_groups,
	output logic                 too_many
);

	cfg_t cfg_q;

	// front to back queue
	logic cq_push;
	cmd_t cq_din;
	logic cq_full;
	logic cq_pop;
	cmd_t cq_dout;
	logic cq_empty;

	// back to result queue
	logic rq_push;
	res_t rq_din;
	logic rq_full;
	res_t rq_dout;

	// config registers, index beyond the list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_size <= TARGET_SIZE_RST;
			cfg_q.open_cost   <= OPEN_COST_RST;
			cfg_q.min_files   <= MIN_FILES_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_TARGET_SIZE: cfg_q.target_size <= cfg_data;
				CFG_OPEN_COST:   cfg_q.open_cost   <= cfg_data;
				CFG_MIN_FILES:   cfg_q.min_files   <= MINF_W'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// classify and number incoming files
	sfbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.file_bytes (file_bytes),
		.last_file  (last_file),
		.q_full     (cq_full),
		.q_push     (cq_push),
		.q_cmd      (cq_din)
	);

	sfbp_cmd_queue u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cq_push),
		.din    (cq_din),
		.full   (cq_full),
		.rd     (cq_pop),
		.dout   (cq_dout),
		.empty  (cq_empty)
	);

	// sort and pack
	sfbp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (cq_empty),
		.q_pop   (cq_pop),
		.q_cmd   (cq_dout),
		.o_full  (rq_full),
		.o_push  (rq_push),
		.o_res   (rq_din)
	);

	sfbp_res_queue u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (rq_push),
		.din    (rq_din),
		.full   (rq_full),
		.rd     (pop),
		.dout   (rq_dout),
		.empty  (empty)
	);

	// result fields out to their own ports
	assign file_slot    = rq_dout.file_slot;
	assign group_number = rq_dout.group_number;
	assign group_end    = rq_dout.group_end;
	assign run_end      = rq_dout.run_end;
	assign no_groups    = rq_dout.no_groups;
	assign too_many     = rq_dout.too_many;

endmodule

>>> dv/tb_sorted_file_bin_packer.sv
// self-checking testbench for the sorted file bin packer, with its own packing predictor
`timescale 1ns / 100ps

module tb_sorted_file_bin_packer import sfbp_pkg::*;;

	// watchdog limit in clock cycles, far above the slowest correct run
	localparam int unsigned CYCLE_LIMIT = 500000;
	// cycles the result side is held off to fill the block up
	localparam int HOLD_CYCLES = 400;
	// settle time after the last result before a register write
	localparam int SETTLE_CYCLES = 20;

	// predicts the grouping of each set and checks the results against it
	class pack_checker;
		logic [SIZE_W-1:0] target;
		logic [SIZE_W-1:0] cost;
		logic [MINF_W-1:0] minf;
		logic [SIZE_W-1:0] sizes [MAX_FILES];
		logic [SLOT_W-1:0] slots [MAX_FILES];
		int                held;
		bit                dropped;
		res_t              set_q[$];
		res_t              pending_groups[$];
		int                errors;

		function new();
			target  = TARGET_SIZE_RST;
			cost    = OPEN_COST_RST;
			minf    = MIN_FILES_RST;
			held    = 0;
			dropped = 1'b0;
			errors  = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
			case (idx)
				CFG_TARGET_SIZE: target = data;
				CFG_OPEN_COST:   cost = data;
				CFG_MIN_FILES:   minf = data[MINF_W-1:0];
				default: ;
			endcase
		endfunction

		// files of one group go out in sorted order
		function void add_group(int from, int upto, int grp);
			res_t r;
			for (int i = from; i <= upto; i++) begin
				r              = '0;
				r.file_slot    = slots[i];
				r.group_number = GRP_W'(grp);
				r.group_end    = (i == upto);
				r.too_many     = dropped;
				set_q.insert(set_q.size(), r);
			end
		endfunction

		function void pack_set();
			logic [TOT_W-1:0]  total;
			logic [SIZE_W:0]   limit;
			int                start;
			int                grp;
			res_t              r;
			set_q.delete();
			limit = {target, 1'b0};
			total = '0;
			start = 0;
			grp   = 0;
			for (int i = 0; i < held; i++) begin
				total = total + sizes[i] + cost;
				if (i > start && total >= limit) begin
					add_group(start, i, grp);
					grp++;
					start = i + 1;
					total = '0;
				end
			end
			// leftover bin only when non-empty and big enough
			if (held > start && (held - start) >= int'(minf)) begin
				add_group(start, held - 1, grp);
				grp++;
			end
			if (set_q.size() == 0) begin
				r           = '0;
				r.run_end   = 1'b1;
				r.no_groups = 1'b1;
				r.too_many  = dropped;
				set_q.insert(0, r);
			end else begin
				set_q[set_q.size() - 1].run_end = 1'b1;
			end
			foreach (set_q[i])
				pending_groups.insert(pending_groups.size(), set_q[i]);
			held    = 0;
			dropped = 1'b0;
		endfunction

		// insertion keeps ties in arrival order; a file past capacity is dropped
		function void take_file(logic [SIZE_W-1:0] size, logic last);
			int pos;
			if (held >= MAX_FILES) begin
				dropped = 1'b1;
			end else begin
				pos = held;
				while (pos > 0 && sizes[pos-1] > size) begin
					sizes[pos] = sizes[pos-1];
					slots[pos] = slots[pos-1];
					pos--;
				end
				sizes[pos] = size;
				slots[pos] = SLOT_W'(held);
				held++;
			end
			if (last)
				pack_set();
		endfunction

		task report(string msg);
			if (errors < 30)
				$display("ERROR at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(res_t got);
			res_t want;
			if (pending_groups.size() == 0) begin
				report($sformatf("unexpected item slot %0d group %0d", got.file_slot,
					got.group_number));
				return;
			end
			want = pending_groups.pop_front();
			if (got !== want)
				report($sformatf({"slot %0d group %0d gend %b rend %b none %b many %b, ",
					"expected slot %0d group %0d gend %b rend %b none %b many %b"},
					got.file_slot, got.group_number, got.group_end, got.run_end,
					got.no_groups, got.too_many, want.file_slot, want.group_number,
					want.group_end, want.run_end, want.no_groups, want.too_many));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [SIZE_W-1:0]    cfg_data = '0;
	logic                 push = 1'b0;
	logic                 full;
	logic [SIZE_W-1:0]    file_bytes = '0;
	logic                 last_file = 1'b0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [SLOT_W-1:0]    file_slot;
	logic [GRP_W-1:0]     group_number;
	logic                 group_end;
	logic                 run_end;
	logic                 no_groups;
	logic                 too_many;

	// idle chances in percent for each side, and the long result hold-off
	int          tx_idle = 0;
	int          rx_idle = 0;
	bit          rx_hold = 1'b0;
	int          files_sent = 0;
	int unsigned cycles = 0;

	pack_checker sb = new();

	sorted_file_bin_packer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.file_bytes   (file_bytes),
		.last_file    (last_file),
		.empty        (empty),
		.pop          (pop),
		.file_slot    (file_slot),
		.group_number (group_number),
		.group_end    (group_end),
		.run_end      (run_end),
		.no_groups    (no_groups),
		.too_many     (too_many)
	);

	always #5 clk = ~clk;

	// watchdog: a hang ends the run as a failure
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_sorted_file_bin_packer NOT OK");
			$finish;
		end
	end

	// result side: pop decided at the falling edge, with random stalls
	always @(negedge clk) begin
		pop <= arst_n && !rx_hold && ($urandom_range(0, 99) >= rx_idle);
	end

	// every popped item goes to the checker, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_result({file_slot, group_number, group_end, run_end, no_groups,
				too_many});
	end

	function automatic logic [SIZE_W-1:0] rand40();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[SIZE_W-1:0];
	endfunction

	// mix of extremes, ties with the previous file, full-range and target-scaled sizes
	function automatic logic [SIZE_W-1:0] pick_size(logic [SIZE_W-1:0] prev);
		logic [63:0] span;
		span = 64'(sb.target) + 64'd1;
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return prev;
			3, 4:    return rand40();
			default: return SIZE_W'(64'(rand40()) % span);
		endcase
	endfunction

	// all drive tasks start and end at a falling edge
	task automatic send_file(input logic [SIZE_W-1:0] size, input logic last);
		while ($urandom_range(0, 99) < tx_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push       <= 1'b1;
		file_bytes <= size;
		last_file  <= last;
		do @(posedge clk); while (full);
		sb.take_file(size, last);
		files_sent++;
		@(negedge clk);
	endtask

	// only called with the block idle
	task automatic write_config(input logic [SIZE_W-1:0] tgt, input logic [SIZE_W-1:0] cst,
			input logic [MINF_W-1:0] mf);
		logic [SIZE_W-1:0]    vals [3];
		logic [CFG_IDX_W-1:0] idxs [3];
		vals = '{tgt, cst, SIZE_W'(mf)};
		idxs = '{CFG_TARGET_SIZE, CFG_OPEN_COST, CFG_MIN_FILES};
		for (int i = 0; i < 3; i++) begin
			cfg_we   <= 1'b1;
			cfg_idx  <= idxs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.write_reg(idxs[i], vals[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// sender pauses until every expected item has come, then lets the block settle
	task automatic close_phase();
		push <= 1'b0;
		while (sb.pending_groups.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic send_set(input int n);
		logic [SIZE_W-1:0] prev;
		logic [SIZE_W-1:0] s;
		prev = rand40();
		for (int i = 0; i < n; i++) begin
			s = pick_size(prev);
			send_file(s, i == n - 1);
			prev = s;
		end
	endtask

	// one optional big set first (to hit a full store), then mostly short sets
	task automatic run_phase(input int quota, input int big);
		int start;
		int n;
		start = files_sent;
		if (big > 0)
			send_set(big);
		while (files_sent - start < quota) begin
			n = ($urandom_range(0, 11) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
			send_set(n);
		end
		close_phase();
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed sets on the reset settings, sender 20 / receiver 57 idle
		tx_idle = 20;
		rx_idle = 57;
		// lone file: leftover below the minimum, so only the no-group marker
		send_file('0, 1'b1);
		// largest and smallest size: one group, sorted order reverses the slots
		send_file('1, 1'b0);
		send_file('0, 1'b1);
		// equal sizes keep arrival order; the single leftover is not emitted
		send_file(40'd200000000, 1'b0);
		send_file(40'd200000000, 1'b0);
		send_file(40'd200000000, 1'b1);
		// five small files reach the minimum count as a leftover bin
		send_file(40'd3000000, 1'b0);
		send_file(40'd1000000, 1'b0);
		send_file(40'd2000000, 1'b0);
		send_file(40'd1000000, 1'b0);
		send_file(40'd0, 1'b1);
		close_phase();

		// zero target closes every pair; an empty leftover stays silent with min 0
		write_config('0, '0, '0);
		send_file(40'd7, 1'b0);
		send_file(40'd5, 1'b1);
		send_file(40'd9, 1'b0);
		send_file(40'd9, 1'b0);
		send_file(40'd1, 1'b1);
		close_phase();

		// random phases, each on its own register settings
		write_config(TARGET_SIZE_RST, OPEN_COST_RST, MIN_FILES_RST);
		run_phase(65, 0);
		// 65 files: the last one is dropped but still starts packing
		write_config('0, '0, '0);
		run_phase(65, 65);

		tx_idle = 57;
		rx_idle = 20;
		// exactly full store, top target and open cost values, a minimum of 64 files
		write_config('1, '1, 7'd64);
		run_phase(65, 64);
		write_config(rand40() >> 10, rand40() >> 16, MINF_W'($urandom_range(0, 64)));
		run_phase(65, 0);

		tx_idle = 0;
		rx_idle = 0;
		write_config(rand40(), rand40(), MINF_W'($urandom_range(0, 64)));
		run_phase(65, 70);
		// receiver holds off long enough to back up the results and then the input
		write_config(40'h10_0000_0000, '0, 7'd1);
		fork
			begin
				rx_hold = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end
		join_none
		run_phase(65, 0);

		if (sb.pending_groups.size() != 0)
			sb.report($sformatf("%0d expected items never came", sb.pending_groups.size()));
		if (sb.errors == 0)
			$display("tb_sorted_file_bin_packer OK");
		else
			$display("tb_sorted_file_bin_packer NOT OK");
		$finish;
	end

endmodule
